@@ src/smf_track_event_parser_top_macros.svh @@
// assertion helpers for the checker file
`ifndef SMF_TRACK_EVENT_PARSER_TOP_MACROS_SVH
`define SMF_TRACK_EVENT_PARSER_TOP_MACROS_SVH

// same-cycle implication, quiet while in reset
`define SMF_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("smf parser check failed");

// next-cycle implication, quiet while in reset
`define SMF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("smf parser check failed");

`endif

@@ src/smf_pkg.sv @@
package smf_pkg;

    localparam int DEF_MAX_VLQ_BYTES = 4;
    localparam int DELTA_W           = 28;

    localparam logic [7:0] ST_META   = 8'hFF;
    localparam logic [7:0] ST_SYSEX  = 8'hF0;
    localparam logic [7:0] ST_ESCAPE = 8'hF7;
    localparam logic [7:0] META_EOT  = 8'h2F;

    typedef enum logic [2:0] {
        PH_DELTA     = 3'd0,
        PH_STATUS    = 3'd1,
        PH_DATA      = 3'd2,
        PH_META_TYPE = 3'd3,
        PH_META_LEN  = 3'd4,
        PH_SYSEX_LEN = 3'd5,
        PH_PAYLOAD   = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        ROLE_DELTA   = 3'd0,
        ROLE_STATUS  = 3'd1,
        ROLE_DATA    = 3'd2,
        ROLE_MTYPE   = 3'd3,
        ROLE_LENGTH  = 3'd4,
        ROLE_PAYLOAD = 3'd5
    } t_role;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_UNKNOWN   = 3'd1,
        ERR_META_LEN  = 3'd2,
        ERR_OVERFLOW  = 3'd3,
        ERR_AFTER_END = 3'd4
    } t_err;

    typedef struct packed {
        logic [7:0]         byte_out;
        logic [2:0]         role;
        logic [7:0]         effective_status;
        logic [DELTA_W-1:0] delta_time;
        logic               delta_done;
        logic               event_done;
        logic               end_of_track;
        logic [2:0]         error;
    } t_result;

    typedef struct packed {
        logic       fixed;
        logic [7:0] len;
    } t_meta_len;

    // meta types whose length the file format pins down
    function automatic t_meta_len meta_fixed_len(input logic [7:0] kind);
        t_meta_len m;
        m.fixed = 1'b1;
        unique case (kind)
            8'h00:    m.len = 8'd2;
            8'h20:    m.len = 8'd1;
            8'h21:    m.len = 8'd1;
            META_EOT: m.len = 8'd0;
            8'h51:    m.len = 8'd3;
            8'h54:    m.len = 8'd5;
            default: begin
                m.fixed = 1'b0;
                m.len   = 8'd0;
            end
        endcase
        return m;
    endfunction

endpackage

@@ src/smf_if.sv @@
interface smf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       track_start;

    modport source (output valid, output data_byte, output track_start, input ready);
    modport sink   (input valid, input data_byte, input track_start, output ready);
endinterface

interface smf_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  byte_out;
    logic [2:0]  role;
    logic [7:0]  effective_status;
    logic [27:0] delta_time;
    logic        delta_done;
    logic        event_done;
    logic        end_of_track;
    logic [2:0]  error;

    modport source (output valid, output byte_out, output role, output effective_status,
                    output delta_time, output delta_done, output event_done,
                    output end_of_track, output error, input ready);
    modport sink   (input valid, input byte_out, input role, input effective_status,
                    input delta_time, input delta_done, input event_done,
                    input end_of_track, input error, output ready);
endinterface

@@ src/smf_parse_core.sv @@
module smf_parse_core #(
    parameter int MAX_VLQ_BYTES = smf_pkg::DEF_MAX_VLQ_BYTES
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    input  logic [7:0]      i_data_byte,
    input  logic            i_track_start,
    output smf_pkg::t_result o_result
);
    import smf_pkg::*;

    localparam int VW = $clog2(MAX_VLQ_BYTES + 1);

    t_phase             r_phase, n_phase, c_phase;
    logic [7:0]         r_rs, n_rs, c_rs;
    logic [7:0]         r_cur, n_cur, c_cur;
    logic [DELTA_W-1:0] r_delta, n_delta, c_delta;
    logic [VW-1:0]      r_vlq, n_vlq, c_vlq;
    logic [DELTA_W-1:0] r_left, n_left, c_left;
    logic [7:0]         r_meta, n_meta, c_meta;
    logic               r_ended, n_ended, c_ended;

    logic [7:0]         b;
    logic [DELTA_W-1:0] acc_delta, acc_left, left_dec;
    logic               vlq_full;
    t_meta_len          fix;
    t_result            res;

    assign b = i_data_byte;

    // track start acts as a reset just ahead of this byte
    always_comb begin
        if (i_track_start) begin
            c_phase = PH_DELTA;
            c_rs    = '0;
            c_cur   = '0;
            c_delta = '0;
            c_vlq   = '0;
            c_left  = '0;
            c_meta  = '0;
            c_ended = 1'b0;
        end else begin
            c_phase = r_phase;
            c_rs    = r_rs;
            c_cur   = r_cur;
            c_delta = r_delta;
            c_vlq   = r_vlq;
            c_left  = r_left;
            c_meta  = r_meta;
            c_ended = r_ended;
        end
    end

    assign acc_delta = {c_delta[DELTA_W-8:0], b[6:0]};
    assign acc_left  = {c_left[DELTA_W-8:0], b[6:0]};
    assign left_dec  = (c_left != '0) ? c_left - DELTA_W'(1) : '0;
    assign vlq_full  = (c_vlq >= VW'(MAX_VLQ_BYTES));
    assign fix       = meta_fixed_len(c_meta);

    always_comb begin
        n_phase = c_phase;
        n_rs    = c_rs;
        n_cur   = c_cur;
        n_delta = c_delta;
        n_vlq   = c_vlq;
        n_left  = c_left;
        n_meta  = c_meta;
        n_ended = c_ended;

        res                  = '0;
        res.byte_out         = b;
        res.role             = ROLE_DELTA;
        res.error            = ERR_NONE;

        if (c_ended) begin
            res.error = ERR_AFTER_END;
        end else begin
            unique case (c_phase)
                PH_DELTA: begin
                    if (vlq_full) begin
                        res.error = ERR_OVERFLOW;
                    end else begin
                        n_vlq = c_vlq + VW'(1);
                    end
                    res.delta_time = acc_delta;
                    if (!b[7]) begin
                        res.delta_done = 1'b1;
                        n_delta        = '0;
                        n_vlq          = '0;
                        n_phase        = PH_STATUS;
                    end else begin
                        n_delta = acc_delta;
                    end
                end
                PH_STATUS: begin
                    if (!b[7]) begin
                        if (c_rs[7] && (c_rs[7:4] != 4'hF)) begin
                            res.role             = ROLE_DATA;
                            res.effective_status = c_rs;
                            n_cur                = c_rs;
                            if (c_rs[7:5] == 3'b110) begin
                                res.event_done = 1'b1;
                                n_phase        = PH_DELTA;
                            end else begin
                                n_left  = DELTA_W'(1);
                                n_phase = PH_DATA;
                            end
                        end else begin
                            res.role       = ROLE_STATUS;
                            res.error      = ERR_UNKNOWN;
                            res.event_done = 1'b1;
                            n_cur          = '0;
                            n_rs           = '0;
                            n_phase        = PH_DELTA;
                        end
                    end else begin
                        res.role             = ROLE_STATUS;
                        res.effective_status = b;
                        n_cur                = b;
                        if (b[7:4] != 4'hF) begin
                            n_rs    = b;
                            n_left  = (b[7:5] == 3'b110) ? DELTA_W'(1) : DELTA_W'(2);
                            n_phase = PH_DATA;
                        end else if (b == ST_META) begin
                            n_rs    = '0;
                            n_phase = PH_META_TYPE;
                        end else if (b == ST_SYSEX || b == ST_ESCAPE) begin
                            n_rs    = '0;
                            n_left  = '0;
                            n_vlq   = '0;
                            n_phase = PH_SYSEX_LEN;
                        end else begin
                            n_rs           = '0;
                            res.error      = ERR_UNKNOWN;
                            res.event_done = 1'b1;
                            n_phase        = PH_DELTA;
                        end
                    end
                end
                PH_DATA: begin
                    res.role             = ROLE_DATA;
                    res.effective_status = c_cur;
                    n_left               = left_dec;
                    if (left_dec == '0) begin
                        res.event_done = 1'b1;
                        n_phase        = PH_DELTA;
                    end
                end
                PH_META_TYPE: begin
                    res.role             = ROLE_MTYPE;
                    res.effective_status = c_cur;
                    n_meta               = b;
                    n_phase              = PH_META_LEN;
                end
                PH_META_LEN: begin
                    res.role             = ROLE_LENGTH;
                    res.effective_status = c_cur;
                    if (fix.fixed && (fix.len != b)) begin
                        res.error = ERR_META_LEN;
                    end
                    if (b == 8'd0) begin
                        res.event_done = 1'b1;
                        if (c_meta == META_EOT) begin
                            res.end_of_track = 1'b1;
                            n_ended          = 1'b1;
                        end
                        n_phase = PH_DELTA;
                    end else begin
                        n_left  = DELTA_W'(b);
                        n_phase = PH_PAYLOAD;
                    end
                end
                PH_SYSEX_LEN: begin
                    res.role             = ROLE_LENGTH;
                    res.effective_status = c_cur;
                    if (vlq_full) begin
                        res.error = ERR_OVERFLOW;
                    end else begin
                        n_vlq = c_vlq + VW'(1);
                    end
                    n_left = acc_left;
                    if (!b[7]) begin
                        n_vlq = '0;
                        if (acc_left == '0) begin
                            res.event_done = 1'b1;
                            n_phase        = PH_DELTA;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    res.role             = ROLE_PAYLOAD;
                    res.effective_status = c_cur;
                    n_left               = left_dec;
                    if (left_dec == '0) begin
                        res.event_done = 1'b1;
                        if (c_cur == ST_META && c_meta == META_EOT) begin
                            res.end_of_track = 1'b1;
                            n_ended          = 1'b1;
                        end
                        n_phase = PH_DELTA;
                    end
                end
                default: begin
                    n_phase = PH_DELTA;
                end
            endcase
        end
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DELTA;
            r_rs    <= '0;
            r_cur   <= '0;
            r_delta <= '0;
            r_vlq   <= '0;
            r_left  <= '0;
            r_meta  <= '0;
            r_ended <= 1'b0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_rs    <= n_rs;
            r_cur   <= n_cur;
            r_delta <= n_delta;
            r_vlq   <= n_vlq;
            r_left  <= n_left;
            r_meta  <= n_meta;
            r_ended <= n_ended;
        end
    end

endmodule

@@ src/smf_track_event_parser_top.sv @@
// standard midi file track parser, one byte of track chunk data per word
// input channel i_in: data_byte plus track_start, which clears the parser so
// that this byte is taken as the first byte of a delta time
// output channel o_out: one word per input byte, the byte passed through and
// tagged with its role, the effective status, the decoded delta, the
// delta/event/end-of-track flags and an error code
// output timing: the tagged word is registered and appears in the cycle after the byte is accepted
// throughput: one byte per cycle while the receiver takes each word, set by the
// single pass through the parse logic between the parser state and the result register
// reset (synchronous, active low): parser back to the delta phase, running
// status cleared, output register empty; no byte is taken while in reset
// output stall: the result register holds its word until taken; a new byte
// is accepted in the same cycle the waiting word leaves, so a stalled
// receiver holds back exactly one word and then pushes back on the input
module smf_track_event_parser_top #(
    parameter int MAX_VLQ_BYTES = smf_pkg::DEF_MAX_VLQ_BYTES
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    smf_in_if.sink  i_in,
    smf_out_if.source o_out
);
    import smf_pkg::*;

    logic    take;
    t_result core_res;

    logic    r_out_valid, n_out_valid;
    t_result r_out;

    // free to take a byte when the result register is empty or being drained
    assign i_in.ready = i_rst_n && (!r_out_valid || o_out.ready);
    assign take       = i_in.valid && i_in.ready;

    // all parse state lives in the core; it advances only on an accepted byte
    smf_parse_core #(
        .MAX_VLQ_BYTES (MAX_VLQ_BYTES)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_data_byte   (i_in.data_byte),
        .i_track_start (i_in.track_start),
        .o_result      (core_res)
    );

    // result register occupancy: fill on take, empty when taken and not refilled
    always_comb begin
        n_out_valid = r_out_valid;
        if (take) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // payload, loaded only with a fresh result
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= core_res;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.byte_out         = r_out.byte_out;
    assign o_out.role             = r_out.role;
    assign o_out.effective_status = r_out.effective_status;
    assign o_out.delta_time       = r_out.delta_time;
    assign o_out.delta_done       = r_out.delta_done;
    assign o_out.event_done       = r_out.event_done;
    assign o_out.end_of_track     = r_out.end_of_track;
    assign o_out.error            = r_out.error;

endmodule

@@ src/smf_checker.sv @@
`include "smf_track_event_parser_top_macros.svh"

module smf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic [7:0]  i_in_data,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  i_out_byte,
    input logic [2:0]  i_out_role,
    input logic [7:0]  i_out_status,
    input logic [27:0] i_out_delta,
    input logic        i_out_delta_done,
    input logic        i_out_event_done,
    input logic [2:0]  i_out_error
);
    import smf_pkg::*;

    // the passed-through byte is the one accepted in the previous cycle
    `SMF_ASSERT_NEXT(a_byte_pass, i_in_valid && i_in_ready, i_out_valid && i_out_byte == $past(i_in_data))

    // a word after end of track carries nothing but the byte and the error
    `SMF_ASSERT_IMPL(a_after_end, i_out_valid && i_out_error == ERR_AFTER_END, i_out_role == ROLE_DELTA && i_out_status == 8'd0 && i_out_delta == 28'd0 && !i_out_event_done)

    // end of a delta is never the end of an event
    `SMF_ASSERT_IMPL(a_delta_role, i_out_valid && i_out_delta_done, i_out_role == ROLE_DELTA && !i_out_event_done)

    // a stalled word holds
    `SMF_ASSERT_NEXT(a_stall_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_byte) && $stable(i_out_error))

endmodule

bind smf_track_event_parser_top smf_checker u_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_in_data        (i_in.data_byte),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_byte       (o_out.byte_out),
    .i_out_role       (o_out.role),
    .i_out_status     (o_out.effective_status),
    .i_out_delta      (o_out.delta_time),
    .i_out_delta_done (o_out.delta_done),
    .i_out_event_done (o_out.event_done),
    .i_out_error      (o_out.error)
);
